FILE: sv/wfrm_pkg.sv
// Package for the windowed frame rate meter: widths, window size, reset values
// and the controller state type. It depends on nothing else.
package wfrm_pkg;

    localparam int WINDOW      = 16;   // ring depth, a power of two from 1 to 256
    localparam int WIN_LOG2    = $clog2(WINDOW);
    localparam int POS_W       = (WINDOW > 1) ? WIN_LOG2 : 1;
    localparam int STAMP_W     = 64;
    localparam int DELTA_W     = 32;
    localparam int SUM_W       = DELTA_W + WIN_LOG2;
    localparam int STAMP_CNT_W = $clog2(STAMP_W);
    localparam int SUM_CNT_W   = (SUM_W > 32) ? $clog2(SUM_W) : 5;
    localparam int QUOT_CNT_W  = $clog2(DELTA_W);

    localparam logic [DELTA_W-1:0] TICK_RATE_RESET = 32'd19200000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_SUM,
        S_DIV,
        S_DONE
    } t_state;

endpackage

FILE: sv/wfrm_delta.sv
// Bit-serial subtractor that forms the saturated tick difference between two stamps.
// Depends on wfrm_pkg for the stamp and difference widths.
module wfrm_delta import wfrm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [STAMP_W-1:0] i_now,
    input  logic [STAMP_W-1:0] i_prev,
    output logic               o_done,
    output logic [DELTA_W-1:0] o_delta
);

    logic [STAMP_W-1:0]     r_a;
    logic [STAMP_W-1:0]     r_b;
    logic [DELTA_W-1:0]     r_lo;
    logic                   r_hi_nz;
    logic                   r_borrow;
    logic [STAMP_CNT_W-1:0] r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic                   diff_bit;
    logic                   n_borrow;

    // One full-subtractor bit per cycle, least significant bit first.
    always_comb begin
        diff_bit = r_a[0] ^ r_b[0] ^ r_borrow;
        n_borrow = (~r_a[0] & r_b[0]) | (~r_a[0] & r_borrow) | (r_b[0] & r_borrow);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STAMP_CNT_W'(STAMP_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a      <= i_now;
            r_b      <= i_prev;
            r_borrow <= 1'b0;
            r_hi_nz  <= 1'b0;
        end else if (r_busy) begin
            r_a      <= r_a >> 1;
            r_b      <= r_b >> 1;
            r_borrow <= n_borrow;
            if (r_cnt < STAMP_CNT_W'(DELTA_W)) begin
                r_lo <= {diff_bit, r_lo[DELTA_W-1:1]};
            end else begin
                r_hi_nz <= r_hi_nz | diff_bit;
            end
        end
    end

    assign o_done  = r_done;
    assign o_delta = r_hi_nz ? {DELTA_W{1'b1}} : r_lo;

endmodule

FILE: sv/wfrm_window.sv
// Ring of recent tick differences and its running sum, updated bit-serially.
// Depends on wfrm_pkg for the window size and the sum width.
module wfrm_window import wfrm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DELTA_W-1:0] i_delta,
    output logic               o_done,
    output logic [DELTA_W-1:0] o_avg
);

    logic [DELTA_W-1:0]   r_ring [WINDOW];
    logic [POS_W-1:0]     r_pos;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     r_d;
    logic [SUM_W-1:0]     r_o;
    logic                 r_c;
    logic                 r_b;
    logic [SUM_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 add_bit;
    logic                 n_c;
    logic                 res_bit;
    logic                 n_b;

    // Sum plus new entry minus the entry it replaces, one bit per cycle.
    always_comb begin
        add_bit = r_sum[0] ^ r_d[0] ^ r_c;
        n_c     = (r_sum[0] & r_d[0]) | (r_sum[0] & r_c) | (r_d[0] & r_c);
        res_bit = add_bit ^ r_o[0] ^ r_b;
        n_b     = (~add_bit & r_o[0]) | (~add_bit & r_b) | (r_o[0] & r_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_pos  <= '0;
            r_sum  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ring[r_pos] <= i_delta;
                if (r_pos == POS_W'(WINDOW - 1)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_sum <= {res_bit, r_sum[SUM_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SUM_CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d <= SUM_W'(i_delta);
            r_o <= SUM_W'(r_ring[r_pos]);
            r_c <= 1'b0;
            r_b <= 1'b0;
        end else if (r_busy) begin
            r_d <= r_d >> 1;
            r_o <= r_o >> 1;
            r_c <= n_c;
            r_b <= n_b;
        end
    end

    // The sum over the window never exceeds WINDOW times the largest entry.
    assign o_done = r_done;
    assign o_avg  = r_sum[SUM_W-1 -: DELTA_W];

endmodule

FILE: sv/wfrm_divider.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on wfrm_pkg for the operand width.
module wfrm_divider import wfrm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DELTA_W-1:0] i_dividend,
    input  logic [DELTA_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DELTA_W-1:0] o_quot
);

    logic [DELTA_W-1:0]    r_q;
    logic [DELTA_W-1:0]    r_rem;
    logic [DELTA_W-1:0]    r_dvs;
    logic [QUOT_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DELTA_W:0]      trial;

    assign trial = {r_rem, r_q[DELTA_W-1]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == QUOT_CNT_W'(DELTA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!trial[DELTA_W]) begin
                r_rem <= trial[DELTA_W-1:0];
                r_q   <= {r_q[DELTA_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DELTA_W-2:0], r_q[DELTA_W-1]};
                r_q   <= {r_q[DELTA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: sv/windowed_frame_rate_meter_top.sv
// Windowed frame rate meter, top level. One word in, one result word out.
// The first word after reset skips the arithmetic. Every later word passes through the serial
// stamp subtract, the serial sum update and, unless the new average is zero, the divider; each
// unit starts when the one before it reports done. One word is in flight at a time, so a new
// word is taken no earlier than the cycle after the previous result is loaded into the output
// register; a result that finds a stalled result still in that register waits in S_DONE.
// Reset (synchronous, active low) clears all history, the ring and the output valid flag;
// tick_rate returns to 19200000.
module windowed_frame_rate_meter_top import wfrm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel: a timestamp word per frame event.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [STAMP_W-1:0] i_timestamp,
    // Output channel: one result word per input word.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [DELTA_W-1:0] o_frame_count,
    output logic [DELTA_W-1:0] o_ticks_per_frame,
    output logic [DELTA_W-1:0] o_frames_per_second,
    output logic               o_primed,
    // Configuration channel: writes the tick_rate register.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [DELTA_W-1:0] i_cfg_data
);

    t_state             r_state;
    t_state             n_state;
    logic [DELTA_W-1:0] r_tick_rate;
    logic [STAMP_W-1:0] r_prev;
    logic               r_have_prev;
    logic [DELTA_W-1:0] r_frames;
    logic               r_primed;
    logic [DELTA_W-1:0] r_rate;
    logic               r_out_valid;
    logic [DELTA_W-1:0] r_out_count;
    logic [DELTA_W-1:0] r_out_avg;
    logic [DELTA_W-1:0] r_out_rate;
    logic               r_out_primed;

    logic               in_accept;
    logic               out_free;
    logic               delta_start;
    logic               delta_done;
    logic [DELTA_W-1:0] delta;
    logic               sum_start;
    logic               sum_done;
    logic [DELTA_W-1:0] avg;
    logic               div_start;
    logic               div_done;
    logic [DELTA_W-1:0] quot;
    logic               rate_zero;
    logic               rate_load;
    logic               out_load;

    // A word is taken only when the controller is idle. The output register
    // lets a new word enter while the previous result still waits downstream.
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Next state and unit start pulses. The very first word after reset has
    // no earlier stamp, so it skips the arithmetic and reports held values.
    always_comb begin
        n_state     = r_state;
        delta_start = 1'b0;
        sum_start   = 1'b0;
        div_start   = 1'b0;
        rate_zero   = 1'b0;
        rate_load   = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (r_have_prev) begin
                        delta_start = 1'b1;
                        n_state     = S_DELTA;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DELTA: begin
                if (delta_done) begin
                    sum_start = 1'b1;
                    n_state   = S_SUM;
                end
            end
            S_SUM: begin
                if (sum_done) begin
                    // A zero average holds the rate at zero instead of dividing.
                    if (avg == '0) begin
                        rate_zero = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    rate_load = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Register file, stamp history and frame counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= TICK_RATE_RESET;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_frames    <= '0;
            r_primed    <= 1'b0;
            r_rate      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tick_rate <= i_cfg_data;
            end
            if (in_accept) begin
                r_prev      <= i_timestamp;
                r_have_prev <= 1'b1;
                r_frames    <= r_frames + 1'b1;
                r_primed    <= r_have_prev;
            end
            if (rate_zero) begin
                r_rate <= '0;
            end else if (rate_load) begin
                r_rate <= quot;
            end
        end
    end

    // Output register: loaded only when empty or being taken, so a stalled
    // result word never changes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count  <= r_frames;
            r_out_avg    <= avg;
            r_out_rate   <= r_rate;
            r_out_primed <= r_primed;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_frame_count       = r_out_count;
    assign o_ticks_per_frame   = r_out_avg;
    assign o_frames_per_second = r_out_rate;
    assign o_primed            = r_out_primed;

    // The subtractor reads the stored stamp in the accept cycle, before it
    // is replaced by the new one.
    wfrm_delta u_delta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (delta_start),
        .i_now   (i_timestamp),
        .i_prev  (r_prev),
        .o_done  (delta_done),
        .o_delta (delta)
    );

    wfrm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sum_start),
        .i_delta (delta),
        .o_done  (sum_done),
        .o_avg   (avg)
    );

    wfrm_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tick_rate),
        .i_divisor  (avg),
        .o_done     (div_done),
        .o_quot     (quot)
    );

endmodule

FILE: sv/wfrm_checker.sv
// Port-level checks for the windowed frame rate meter, bound to its top level.
// Depends on wfrm_pkg for the field widths.
module wfrm_checker import wfrm_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [DELTA_W-1:0] o_frame_count,
    input logic [DELTA_W-1:0] o_ticks_per_frame,
    input logic [DELTA_W-1:0] o_frames_per_second,
    input logic               o_primed
);

    // A stalled result word keeps its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_count)
            && $stable(o_ticks_per_frame) && $stable(o_frames_per_second)
            && $stable(o_primed))
        else $error("result word changed while stalled");

    // Only one word is in flight: the input stalls right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a word was still in flight");

    // A zero average always reports a zero rate.
    a_zero_avg_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_ticks_per_frame == '0) |-> (o_frames_per_second == '0))
        else $error("nonzero rate with zero average");

    // An unprimed result only happens on the first frame, with nothing averaged.
    a_unprimed_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_primed |-> (o_frame_count == DELTA_W'(1))
            && (o_ticks_per_frame == '0) && (o_frames_per_second == '0))
        else $error("unprimed result is not the first frame");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

endmodule

bind windowed_frame_rate_meter_top wfrm_checker u_wfrm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_frame_count       (o_frame_count),
    .o_ticks_per_frame   (o_ticks_per_frame),
    .o_frames_per_second (o_frames_per_second),
    .o_primed            (o_primed)
);

FILE: tb/windowed_frame_rate_meter_top_tb.sv
// Self-checking testbench for windowed_frame_rate_meter_top: directed and random frame
// timestamps, random idling on both channels and tick_rate changes between blocks.
// Depends on wfrm_pkg and the top-level RTL only.
`timescale 1ns / 100ps

import wfrm_pkg::*;

// Tracks the meter's state alongside the block and holds the results it must produce.
class t_rate_scoreboard;
    typedef struct {
        logic [DELTA_W-1:0] frame_count;
        logic [DELTA_W-1:0] ticks_per_frame;
        logic [DELTA_W-1:0] frames_per_second;
        logic               primed;
    } t_meter_result;

    logic [DELTA_W-1:0] tick_rate;
    logic [STAMP_W-1:0] last_stamp;
    bit                 have_last;
    logic [DELTA_W-1:0] delta_ring [WINDOW];
    int unsigned        ring_pos;
    logic [SUM_W-1:0]   ring_sum;
    logic [DELTA_W-1:0] frames;
    logic [DELTA_W-1:0] avg_ticks;
    logic [DELTA_W-1:0] rate;
    t_meter_result      expected_q [$];
    int                 errors;
    int                 results_seen;

    function new();
        tick_rate    = TICK_RATE_RESET;
        last_stamp   = '0;
        have_last    = 1'b0;
        foreach (delta_ring[i]) delta_ring[i] = '0;
        ring_pos     = 0;
        ring_sum     = '0;
        frames       = '0;
        avg_ticks    = '0;
        rate         = '0;
        errors       = 0;
        results_seen = 0;
    endfunction

    // Works out the result caused by one accepted timestamp word.
    function void note_word(logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0] diff;
        logic [DELTA_W-1:0] delta;
        logic [SUM_W-1:0]   quot;
        t_meter_result      res;
        res.primed = have_last;
        if (have_last) begin
            // The difference wraps modulo 2^64, then saturates to 32 bits.
            diff  = stamp - last_stamp;
            delta = (diff > 64'h0000_0000_FFFF_FFFF) ? '1 : diff[DELTA_W-1:0];
            ring_sum = ring_sum - delta_ring[ring_pos] + delta;
            delta_ring[ring_pos] = delta;
            ring_pos  = (ring_pos + 1) % WINDOW;
            quot      = ring_sum / SUM_W'(WINDOW);
            avg_ticks = quot[DELTA_W-1:0];
            rate      = (avg_ticks != '0) ? tick_rate / avg_ticks : '0;
        end
        last_stamp = stamp;
        have_last  = 1'b1;
        frames     = frames + 1'b1;
        res.frame_count       = frames;
        res.ticks_per_frame   = avg_ticks;
        res.frames_per_second = rate;
        expected_q.push_back(res);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Compares one accepted result word with the oldest expectation.
    task check_word(input logic [DELTA_W-1:0] fc, input logic [DELTA_W-1:0] tpf,
                    input logic [DELTA_W-1:0] fps, input logic pr);
        t_meter_result want;
        results_seen++;
        if (expected_q.size() == 0) begin
            report("result with no word waiting", fc, 0);
            return;
        end
        want = expected_q.pop_front();
        if (fc !== want.frame_count)        report("frame_count", fc, want.frame_count);
        if (tpf !== want.ticks_per_frame)   report("ticks_per_frame", tpf, want.ticks_per_frame);
        if (fps !== want.frames_per_second) report("frames_per_second", fps,
                                                   want.frames_per_second);
        if (pr !== want.primed)             report("primed", pr, want.primed);
    endtask
endclass

module windowed_frame_rate_meter_top_tb;

    // Watchdog limit on the run length, set with a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT  = 3_000_000;
    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_CYCLES  = 2000;
    // Quiet cycles after the last result, longer than the block's latency for a word when the output does not stall.
    localparam int TAIL_CYCLES  = 160;
    localparam int PHASES       = 3;
    localparam int BLOCKS       = 7;
    localparam int BLOCK_WORDS  = 95;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [STAMP_W-1:0] timestamp;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DELTA_W-1:0] frame_count;
    logic [DELTA_W-1:0] ticks_per_frame;
    logic [DELTA_W-1:0] frames_per_second;
    logic               primed;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [DELTA_W-1:0] cfg_data;

    t_rate_scoreboard   sb;
    int                 words_sent = 0;
    int                 cycle_count = 0;
    // Idle percentages, set per phase by the stimulus process.
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    // Hold-off requests are counted by the stimulus and served by the receiver process.
    int                 hold_requests = 0;
    int                 hold_served = 0;
    int                 hold_left = 0;

    windowed_frame_rate_meter_top dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_timestamp         (timestamp),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_frame_count       (frame_count),
        .o_ticks_per_frame   (ticks_per_frame),
        .o_frames_per_second (frames_per_second),
        .o_primed            (primed),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_data          (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake must not stall the run forever.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("windowed_frame_rate_meter_top test failed");
            $finish;
        end
    end

    // Receiver: random stall at the phase's rate, or a long hold-off when one is requested.
    // The hold-off is counted here so that the sender keeps offering words meanwhile.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: all handshakes are sampled at the rising edge, where every signal still holds
    // the value the block saw. Register writes take effect for the words that follow them.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.tick_rate = cfg_data;
            if (in_valid && !in_stall) sb.note_word(timestamp);
            if (out_valid && !out_stall)
                sb.check_word(frame_count, ticks_per_frame, frames_per_second, primed);
        end
    end

    // Offers one timestamp word, with random idle cycles ahead of it, and returns at the
    // edge where it is accepted. Valid stays high so the next word can follow directly.
    task automatic send_word(input logic [STAMP_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        timestamp <= stamp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Stops sending and waits until every result word has come back.
    task automatic drain();
        if (in_valid) in_valid <= 1'b0;
        while (sb.results_seen != words_sent) @(posedge clk);
    endtask

    // Writes tick_rate; only called once the block has drained.
    task automatic write_tick_rate(input logic [DELTA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Rates mix the extremes, the reset rate and arbitrary 32-bit values.
    function automatic logic [DELTA_W-1:0] pick_tick_rate();
        case ($urandom_range(5))
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return TICK_RATE_RESET;
            3:       return 32'd90000;
            default: return $urandom;
        endcase
    endfunction

    // Nominal frame period in ticks; the spread keeps the average across many magnitudes.
    function automatic logic [STAMP_W-1:0] pick_period();
        case ($urandom_range(3))
            0:       return $urandom_range(1, 64);
            1:       return $urandom_range(64, 32'h0001_0000);
            2:       return $urandom_range(32'h0001_0000, 32'h0100_0000);
            default: return $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
        endcase
    endfunction

    // Mostly a steady frame clock with jitter; the rest are tiny steps, large jumps that
    // saturate, random 32-bit steps, backward steps and fully random stamps.
    function automatic logic [STAMP_W-1:0] next_stamp(logic [STAMP_W-1:0] prev,
                                                      logic [STAMP_W-1:0] period);
        int unsigned pick;
        logic [31:0] jitter;
        pick   = $urandom_range(99);
        jitter = 32'(period >> 4);
        if (pick < 70)      return prev + period + $urandom_range(0, jitter);
        else if (pick < 78) return prev + $urandom_range(0, 3);
        else if (pick < 84) return prev + $urandom;
        else if (pick < 89) return prev + {24'd0, 8'($urandom_range(1, 255)), $urandom};
        else if (pick < 94) return prev - $urandom_range(1, 1000);
        else                return {$urandom, $urandom};
    endfunction

    initial begin
        logic [STAMP_W-1:0] cur_stamp;
        logic [STAMP_W-1:0] period;

        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        timestamp = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // First phase of idling: sender idles rarely, receiver often.
        send_idle_pct = 18;
        recv_idle_pct = 64;

        // Directed part. The first word after reset has no history, and a previous stamp
        // of zero still counts as history, giving a zero difference and a zero rate.
        send_word(64'd0);
        send_word(64'd0);
        send_word(64'd1000);
        // A jump larger than 32 bits saturates, and wrapping past the top gives a delta of 1.
        send_word(64'hFFFF_FFFF_FFFF_FFFF);
        send_word(64'd0);
        // Going backwards wraps modulo 2^64 and then saturates.
        send_word(64'd5);
        send_word(64'd3);
        // Exactly the largest delta that fits, then one past it.
        cur_stamp = 64'd3 + 64'hFFFF_FFFF;
        send_word(cur_stamp);
        cur_stamp = cur_stamp + 64'h1_0000_0000;
        send_word(cur_stamp);
        // A steady 60 frames per second at the reset rate, long enough to wrap the ring.
        repeat (12) begin
            cur_stamp = cur_stamp + 64'd320000;
            send_word(cur_stamp);
        end
        // A zero rate divides to zero; the largest and the smallest nonzero rates follow.
        drain();
        write_tick_rate(32'd0);
        cur_stamp = cur_stamp + 64'd320000;
        send_word(cur_stamp);
        drain();
        write_tick_rate(32'hFFFF_FFFF);
        cur_stamp = cur_stamp + 64'd320000;
        send_word(cur_stamp);
        drain();
        write_tick_rate(32'd1);
        cur_stamp = cur_stamp + 64'd320000;
        send_word(cur_stamp);

        // Random part in three idling phases. Each block drains, picks a new rate and a
        // new frame period; one block per phase also holds the receiver off for a long while.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 64;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < BLOCKS; blk++) begin
                drain();
                write_tick_rate(pick_tick_rate());
                period = pick_period();
                if (blk == 3) hold_requests <= hold_requests + 1;
                for (int n = 0; n < BLOCK_WORDS; n++) begin
                    cur_stamp = next_stamp(cur_stamp, period);
                    send_word(cur_stamp);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report("results still missing at end", sb.expected_q.size(), 0);
        if (sb.errors == 0) begin
            $display("windowed_frame_rate_meter_top test passed");
        end else begin
            $display("windowed_frame_rate_meter_top test failed");
        end
        $finish;
    end

endmodule
